>>> design/lmsb_pkg.sv
`default_nettype none
package lmsb_pkg;

  // opcodes of the input word
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_SHIFT  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // rows per frame and bits of a row index or display index
  localparam int ROWS   = 8;
  localparam int ROW_W  = 3;
  localparam int DISP_W = 3;

  // commands from controller to datapath
  typedef struct packed {
    logic              append;
    logic              shift;
    logic              clear;
    logic              rd_zero;
    logic [ROW_W-1:0]  rd_row;
    logic [DISP_W-1:0] rd_disp;
  } cmd_t;

endpackage
`default_nettype wire

>>> design/lmsb_datapath.sv
`default_nettype none
module lmsb_datapath #(
  parameter int DISPLAYS = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lmsb_pkg::cmd_t cmd,
  input  wire logic [63:0]   frame_bytes,
  output logic [7:0]         row_data
);

  localparam int FRAMES = DISPLAYS + 1;
  localparam int WORD_W = 8 * FRAMES;

  // one word per row, frame 0 in the bottom byte, last frame in the top byte
  logic [WORD_W-1:0] store_r   [lmsb_pkg::ROWS];
  logic [WORD_W-1:0] store_nxt [lmsb_pkg::ROWS];
  logic [2:0]        count_r, count_nxt;
  logic [2:0]        phase_r, phase_nxt;
  logic              fits;
  logic [WORD_W-1:0] rd_word;

  assign fits = ({1'b0, count_r} <= 4'(DISPLAYS));

  // store, write count and column phase update
  always_comb begin
    count_nxt = count_r;
    phase_nxt = phase_r;
    for (int r = 0; r < lmsb_pkg::ROWS; r++) begin
      store_nxt[r] = store_r[r];
    end
    if (cmd.append && fits) begin
      // slot DISPLAYS - count sits at byte offset count
      for (int r = 0; r < lmsb_pkg::ROWS; r++) begin
        for (int f = 0; f < FRAMES; f++) begin
          if ({1'b0, count_r} == 4'(f)) begin
            store_nxt[r][8*f +: 8] = frame_bytes[8*r +: 8];
          end
        end
      end
      if (count_r != 3'd7) begin
        count_nxt = count_r + 3'd1;
      end
    end else if (cmd.shift) begin
      // whole row shifts left, carrying the top bit of the next frame
      for (int r = 0; r < lmsb_pkg::ROWS; r++) begin
        store_nxt[r] = store_r[r] << 1;
      end
      phase_nxt = phase_r + 3'd1;
      if (phase_r == 3'd7 && count_r != 3'd0) begin
        count_nxt = count_r - 3'd1;
      end
    end else if (cmd.clear) begin
      for (int r = 0; r < lmsb_pkg::ROWS; r++) begin
        store_nxt[r] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      phase_r <= '0;
      for (int r = 0; r < lmsb_pkg::ROWS; r++) begin
        store_r[r] <= '0;
      end
    end else begin
      count_r <= count_nxt;
      phase_r <= phase_nxt;
      for (int r = 0; r < lmsb_pkg::ROWS; r++) begin
        store_r[r] <= store_nxt[r];
      end
    end
  end

  // row readout: display d lives at byte offset DISPLAYS - d
  assign rd_word = store_r[cmd.rd_row];

  always_comb begin
    row_data = '0;
    for (int d = 0; d < DISPLAYS; d++) begin
      if (cmd.rd_disp == 3'(d)) begin
        row_data = rd_word[8*(DISPLAYS-d) +: 8];
      end
    end
    if (cmd.rd_zero) begin
      row_data = '0;
    end
  end

endmodule
`default_nettype wire

>>> design/lmsb_ctrl.sv
`default_nettype none
module lmsb_ctrl #(
  parameter int DISPLAYS = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [1:0]     opcode,
  output logic                busy,
  output lmsb_pkg::cmd_t      cmd,
  output logic                strobe,
  output logic                broadcast,
  output logic [1:0]          target_display,
  output logic [3:0]          row_address,
  output logic                last
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  localparam logic [lmsb_pkg::DISP_W-1:0] LAST_DISP = lmsb_pkg::DISP_W'(DISPLAYS - 1);

  logic [1:0]                  state_r, state_nxt;
  logic [lmsb_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [lmsb_pkg::DISP_W-1:0] disp_r, disp_nxt;
  logic                        take;
  logic                        row_end;

  assign busy    = (state_r != ST_IDLE);
  assign take    = start && !busy;
  assign row_end = (row_r == 3'd7);

  // result word fields
  assign strobe         = busy;
  assign broadcast      = (state_r == ST_CLEAR);
  assign target_display = (state_r == ST_SHIFT) ? disp_r[1:0] : 2'd0;
  assign row_address    = {1'b0, row_r} + 4'd1;
  assign last           = row_end && ((state_r == ST_CLEAR) ||
                                      (state_r == ST_SHIFT && disp_r == LAST_DISP));

  // datapath commands
  always_comb begin
    cmd         = '0;
    cmd.append  = take && (opcode == lmsb_pkg::OP_APPEND);
    cmd.shift   = take && (opcode == lmsb_pkg::OP_SHIFT);
    cmd.clear   = take && (opcode == lmsb_pkg::OP_CLEAR);
    cmd.rd_zero = (state_r != ST_SHIFT);
    cmd.rd_row  = row_r;
    cmd.rd_disp = disp_r;
  end

  // sequencer over displays and rows
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    disp_nxt  = disp_r;
    case (state_r)
      ST_IDLE: begin
        row_nxt  = '0;
        disp_nxt = '0;
        if (take) begin
          case (opcode)
            lmsb_pkg::OP_SHIFT: state_nxt = ST_SHIFT;
            lmsb_pkg::OP_CLEAR: state_nxt = ST_CLEAR;
            default:            state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SHIFT: begin
        row_nxt = row_r + 3'd1;
        if (row_end) begin
          disp_nxt = disp_r + 3'd1;
          if (disp_r == LAST_DISP) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_CLEAR: begin
        row_nxt = row_r + 3'd1;
        if (row_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
      disp_r  <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      disp_r  <= disp_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/led_matrix_scroll_buffer.sv
// output: a shift gives its first word in the cycle after acceptance, then one word a cycle,
//   8*DISPLAYS words; a clear gives 8 words the same way; append and no-op give none
// flow: the row sequencer emits one word per cycle and takes no new start while busy;
//   the receiver cannot stall
// reset: synchronous active low, clears the row store, write count and column phase
`default_nettype none
module led_matrix_scroll_buffer #(
  parameter int DISPLAYS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [63:0] in_frame_bytes,
  output logic             out_strobe,
  output logic             out_broadcast,
  output logic [1:0]       out_target_display,
  output logic [3:0]       out_row_address,
  output logic [7:0]       out_row_data,
  output logic             out_last
);

  lmsb_pkg::cmd_t cmd;

  // sequencer
  lmsb_ctrl #(
    .DISPLAYS(DISPLAYS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .opcode        (in_opcode),
    .busy          (busy),
    .cmd           (cmd),
    .strobe        (out_strobe),
    .broadcast     (out_broadcast),
    .target_display(out_target_display),
    .row_address   (out_row_address),
    .last          (out_last)
  );

  // row store and counters
  lmsb_datapath #(
    .DISPLAYS(DISPLAYS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .frame_bytes(in_frame_bytes),
    .row_data   (out_row_data)
  );

endmodule
`default_nettype wire
